// ===== rtl/assert_macros.svh =====
// assertion macros used by the directory top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/salru_pkg.sv =====
// types and constants of the size-aware lru directory
package salru_pkg;

   localparam int DEFAULT_MAX_SLOTS = 16;
   localparam int AGE_W     = 32;
   localparam int TAG_W     = 64;
   localparam int LEN_W     = 23;
   localparam int BYTES_W   = 25;
   localparam int LIMIT_W   = 5;
   localparam int SLOT_O_W  = 4;
   localparam int CNT_O_W   = 5;

   localparam logic [BYTES_W-1:0] BUDGET_CAP = 25'h100_0000;
   localparam logic [LEN_W-1:0]   ENTRY_CAP  = 23'h40_0000;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic CSR_ENTRY_LIMIT = 1'b0;
   localparam logic CSR_BYTE_BUDGET = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SCAN_MATCH,
      SCAN_FREE,
      SCAN_OLDEST
   } scan_mode_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_STAMP,
      CMD_FILL,
      CMD_EVICT,
      CMD_CLEAR
   } cmd_op_type;

   // running search result handed from cell to cell
   typedef struct packed {
      logic              found;
      logic [AGE_W-1:0]  age;
      logic [LEN_W-1:0]  size;
   } carry_type;

   // update broadcast to all cells
   typedef struct packed {
      cmd_op_type        op;
      logic [AGE_W-1:0]  age;
      logic [LEN_W-1:0]  size;
   } cmd_type;

endpackage

// ===== rtl/salru_cell.sv =====
// one directory slot with its link of the search chain
module salru_cell #(
   parameter int MAX_SLOTS = salru_pkg::DEFAULT_MAX_SLOTS,
   parameter int IDX       = 0,
   parameter int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [CNT_W-1:0]              limit,
   input  salru_pkg::scan_mode_type      mode,
   input  logic [salru_pkg::TAG_W-1:0]   req_tag,
   input  logic [salru_pkg::LEN_W-1:0]   req_klen,
   input  salru_pkg::cmd_type            cmd,
   input  logic [SLOT_W-1:0]             cmd_idx,
   input  salru_pkg::carry_type          carry_in,
   input  logic [SLOT_W-1:0]             carry_idx_in,
   output salru_pkg::carry_type          carry_out,
   output logic [SLOT_W-1:0]             carry_idx_out
);
   import salru_pkg::*;

   logic              valid_ff, valid_in;
   logic [TAG_W-1:0]  tag_ff;
   logic [LEN_W-1:0]  klen_ff;
   logic [LEN_W-1:0]  size_ff;
   logic [AGE_W-1:0]  age_ff;
   carry_type         carry_ff, carry_in_next;
   logic [SLOT_W-1:0] cidx_ff, cidx_in;
   logic              in_range, selected, take;

   assign in_range = CNT_W'(IDX) < limit;
   assign selected = (cmd_idx == SLOT_W'(IDX));

   always_comb begin
      case (mode)
         SCAN_MATCH:  take = !carry_in.found && in_range && valid_ff &&
                             (tag_ff == req_tag) && (klen_ff == req_klen);
         SCAN_FREE:   take = !carry_in.found && in_range && !valid_ff;
         SCAN_OLDEST: take = in_range && valid_ff &&
                             (!carry_in.found || (age_ff < carry_in.age));
         default:     take = 1'b0;
      endcase
      if (take) begin
         carry_in_next = '{found: 1'b1, age: age_ff, size: size_ff};
         cidx_in       = SLOT_W'(IDX);
      end else begin
         carry_in_next = carry_in;
         cidx_in       = carry_idx_in;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.op == CMD_CLEAR) begin
         valid_in = 1'b0;
      end else if (selected && cmd.op == CMD_FILL) begin
         valid_in = 1'b1;
      end else if (selected && cmd.op == CMD_EVICT) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         carry_ff.found <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         carry_ff.found <= carry_in_next.found;
      end
      carry_ff.age  <= carry_in_next.age;
      carry_ff.size <= carry_in_next.size;
      cidx_ff       <= cidx_in;
      if (selected && cmd.op == CMD_FILL) begin
         tag_ff  <= req_tag;
         klen_ff <= req_klen;
         size_ff <= cmd.size;
      end
      if (selected && (cmd.op == CMD_FILL || cmd.op == CMD_STAMP)) begin
         age_ff <= cmd.age;
      end
   end

   assign carry_out     = carry_ff;
   assign carry_idx_out = cidx_ff;

endmodule

// ===== rtl/size_aware_lru_cache_directory_top.sv =====
// Directory for a byte-budgeted lru cache: one slot per cell in a chain; a search walks the
// chain one cell per cycle. A clear, an unused request or a bypassed request goes straight
// to the finish state; a lookup runs one search pass, and an insert that evicts k entries
// runs k + 1 passes, one per eviction and a last one; one item is in work at a time.
module size_aware_lru_cache_directory_top #(
   parameter int MAX_SLOTS = salru_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [salru_pkg::BYTES_W-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [salru_pkg::TAG_W-1:0]    req_key_tag,
   input  logic [salru_pkg::LEN_W-1:0]    req_key_length,
   input  logic [salru_pkg::LEN_W-1:0]    req_entry_bytes,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_bypassed,
   output logic                           rsp_hit,
   output logic [salru_pkg::SLOT_O_W-1:0] rsp_slot,
   output logic                           rsp_admitted,
   output logic [salru_pkg::CNT_O_W-1:0]  rsp_evicted_count,
   output logic [salru_pkg::BYTES_W-1:0]  rsp_evicted_total,
   output logic [salru_pkg::BYTES_W-1:0]  rsp_occupied_bytes,
   output logic [salru_pkg::CNT_O_W-1:0]  rsp_entry_count
);
   import salru_pkg::*;
   `include "assert_macros.svh"

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SCAN_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic [LIMIT_W-1:0] entry_limit_ff;
   logic [BYTES_W-1:0] byte_budget_ff;

   state_type          state_ff, state_in;
   scan_mode_type      mode_ff, mode_in;
   logic [SCAN_W-1:0]  cnt_ff, cnt_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [LEN_W-1:0]   klen_ff, klen_in;
   logic [LEN_W-1:0]   eb_ff, eb_in;
   logic [AGE_W-1:0]   age_clock_ff, age_clock_in;
   logic [BYTES_W-1:0] held_bytes_ff, held_bytes_in;
   logic [CNT_W-1:0]   held_count_ff, held_count_in;
   logic [CNT_W-1:0]   ev_count_ff, ev_count_in;
   logic [BYTES_W-1:0] ev_total_ff, ev_total_in;
   logic               res_bypass_ff, res_bypass_in;
   logic               res_hit_ff, res_hit_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic               res_admit_ff, res_admit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               load_rsp;

   logic [CNT_W-1:0]   limit;
   logic [BYTES_W-1:0] budget;
   logic               req_take, bypass_cond, fits;
   cmd_type            cmd;
   logic [SLOT_W-1:0]  cmd_idx;

   carry_type          carry [0:MAX_SLOTS];
   logic [SLOT_W-1:0]  carry_idx [0:MAX_SLOTS];
   carry_type          last;
   logic [SLOT_W-1:0]  last_idx;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_limit_ff <= LIMIT_W'(16);
         byte_budget_ff <= BUDGET_CAP;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENTRY_LIMIT: entry_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_BYTE_BUDGET: byte_budget_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(entry_limit_ff) > 32'(MAX_SLOTS)) begin
         limit = CNT_W'(MAX_SLOTS);
      end else begin
         limit = CNT_W'(entry_limit_ff);
      end
      budget = (byte_budget_ff > BUDGET_CAP) ? BUDGET_CAP : byte_budget_ff;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign bypass_cond = (limit == '0) || (budget == '0) ||
                        (req_entry_bytes > ENTRY_CAP) ||
                        (BYTES_W'(req_entry_bytes) > budget);
   assign fits = ((26'(held_bytes_ff) + 26'(eb_ff)) <= 26'(budget)) &&
                 (held_count_ff < limit);
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // cell chain
   assign carry[0]     = '{found: 1'b0, age: '0, size: '0};
   assign carry_idx[0] = '0;

   for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
      salru_cell #(
         .MAX_SLOTS (MAX_SLOTS),
         .IDX       (k),
         .SLOT_W    (SLOT_W),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .limit         (limit),
         .mode          (mode_ff),
         .req_tag       (tag_ff),
         .req_klen      (klen_ff),
         .cmd           (cmd),
         .cmd_idx       (cmd_idx),
         .carry_in      (carry[k]),
         .carry_idx_in  (carry_idx[k]),
         .carry_out     (carry[k+1]),
         .carry_idx_out (carry_idx[k+1])
      );
   end

   assign last     = carry[MAX_SLOTS];
   assign last_idx = carry_idx[MAX_SLOTS];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_type == REQ_LOOKUP && !bypass_cond) begin
                  state_in = ST_SCAN;
               end else if (req_type == REQ_INSERT && !bypass_cond) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CHECK: state_in = ST_SCAN;
         ST_SCAN: begin
            if (cnt_ff == SCAN_W'(MAX_SLOTS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (mode_ff == SCAN_OLDEST && last.found) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and cell commands
   always_comb begin
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      tag_in        = tag_ff;
      klen_in       = klen_ff;
      eb_in         = eb_ff;
      age_clock_in  = age_clock_ff;
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      ev_count_in   = ev_count_ff;
      ev_total_in   = ev_total_ff;
      res_bypass_in = res_bypass_ff;
      res_hit_in    = res_hit_ff;
      res_slot_in   = res_slot_ff;
      res_admit_in  = res_admit_ff;
      cmd           = '{op: CMD_NONE, age: '0, size: '0};
      cmd_idx       = last_idx;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               tag_in        = req_key_tag;
               klen_in       = req_key_length;
               eb_in         = req_entry_bytes;
               ev_count_in   = '0;
               ev_total_in   = '0;
               res_bypass_in = 1'b0;
               res_hit_in    = 1'b0;
               res_slot_in   = '0;
               res_admit_in  = 1'b0;
               mode_in       = SCAN_MATCH;
               cnt_in        = '0;
               if (req_type == REQ_CLEAR) begin
                  cmd.op        = CMD_CLEAR;
                  age_clock_in  = '0;
                  held_bytes_in = '0;
                  held_count_in = '0;
               end else if (req_type == REQ_LOOKUP || req_type == REQ_INSERT) begin
                  res_bypass_in = bypass_cond;
               end
            end
         end
         ST_CHECK: begin
            cnt_in  = '0;
            mode_in = fits ? SCAN_FREE : SCAN_OLDEST;
         end
         ST_SCAN: cnt_in = cnt_ff + SCAN_W'(1);
         ST_DECIDE: begin
            if (last.found) begin
               case (mode_ff)
                  SCAN_MATCH: begin
                     age_clock_in = age_clock_ff + AGE_W'(1);
                     cmd          = '{op: CMD_STAMP, age: age_clock_in, size: '0};
                     res_hit_in   = 1'b1;
                     res_slot_in  = last_idx;
                  end
                  SCAN_FREE: begin
                     age_clock_in  = age_clock_ff + AGE_W'(1);
                     cmd           = '{op: CMD_FILL, age: age_clock_in, size: eb_ff};
                     held_bytes_in = held_bytes_ff + BYTES_W'(eb_ff);
                     held_count_in = held_count_ff + CNT_W'(1);
                     res_admit_in  = 1'b1;
                     res_slot_in   = last_idx;
                  end
                  SCAN_OLDEST: begin
                     cmd           = '{op: CMD_EVICT, age: '0, size: '0};
                     held_bytes_in = held_bytes_ff - BYTES_W'(last.size);
                     held_count_in = held_count_ff - CNT_W'(1);
                     ev_count_in   = ev_count_ff + CNT_W'(1);
                     ev_total_in   = ev_total_ff + BYTES_W'(last.size);
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= SCAN_MATCH;
         cnt_ff        <= '0;
         age_clock_ff  <= '0;
         held_bytes_ff <= '0;
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         cnt_ff        <= cnt_in;
         age_clock_ff  <= age_clock_in;
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tag_ff        <= tag_in;
      klen_ff       <= klen_in;
      eb_ff         <= eb_in;
      ev_count_ff   <= ev_count_in;
      ev_total_ff   <= ev_total_in;
      res_bypass_ff <= res_bypass_in;
      res_hit_ff    <= res_hit_in;
      res_slot_ff   <= res_slot_in;
      res_admit_ff  <= res_admit_in;
      if (load_rsp) begin
         rsp_bypassed       <= res_bypass_ff;
         rsp_hit            <= res_hit_ff;
         rsp_slot           <= SLOT_O_W'(res_slot_ff);
         rsp_admitted       <= res_admit_ff;
         rsp_evicted_count  <= CNT_O_W'(ev_count_ff);
         rsp_evicted_total  <= ev_total_ff;
         rsp_occupied_bytes <= held_bytes_ff;
         rsp_entry_count    <= CNT_O_W'(held_count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, 32'(held_count_ff) <= MAX_SLOTS)
   `ASSERT_NEXT(a_clear_empties, clock, reset, req_take && req_type == REQ_CLEAR,
                held_count_ff == '0 && held_bytes_ff == '0)
   `ASSERT_IMPLY(a_evict_has_entry, clock, reset,
                 state_ff == ST_DECIDE && mode_ff == SCAN_OLDEST && last.found,
                 held_count_ff != '0)

endmodule

// ===== verif/tb_top.sv =====
// testbench for the size-aware lru cache directory: table-driven and random requests
module tb_top;
   import salru_pkg::*;

   localparam int NSLOT = 16;
   localparam int RAND_ITEMS = 1150;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic              bypassed;
      logic              hit;
      logic [3:0]        slot;
      logic              admitted;
      logic [4:0]        ev_count;
      logic [24:0]       ev_total;
      logic [24:0]       occ_bytes;
      logic [4:0]        occ_count;
   } answer_type;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] tag;
      logic [22:0] klen;
      logic [22:0] ebytes;
      logic        has_answer;
      answer_type  answer;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [24:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic [63:0] req_key_tag = '0;
   logic [22:0] req_key_length = '0;
   logic [22:0] req_entry_bytes = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_bypassed, rsp_hit, rsp_admitted;
   logic [3:0] rsp_slot;
   logic [4:0] rsp_evicted_count, rsp_entry_count;
   logic [24:0] rsp_evicted_total, rsp_occupied_bytes;

   size_aware_lru_cache_directory_top i_dut (.*);

   always #5 clock = ~clock;

   // directory mirror
   logic [4:0]  cfg_limit;
   logic [24:0] cfg_budget;
   logic        dir_valid [NSLOT];
   logic [63:0] dir_tag [NSLOT];
   logic [22:0] dir_klen [NSLOT];
   logic [22:0] dir_size [NSLOT];
   logic [31:0] dir_age [NSLOT];
   logic [31:0] age_now;
   logic [24:0] held_bytes;
   logic [4:0]  held_count;

   answer_type pending_answers[$];
   int errors = 0;
   int idle_cycles = 0;

   // pools of recently used keys so lookups hit often
   logic [63:0] tag_pool [8];
   logic [22:0] klen_pool [8];

   function automatic void wipe_directory();
      for (int i = 0; i < NSLOT; i++) dir_valid[i] = 1'b0;
      age_now = '0;
      held_bytes = '0;
      held_count = '0;
   endfunction

   function automatic answer_type predict_answer(logic [1:0] kind, logic [63:0] tag,
                                                 logic [22:0] klen, logic [22:0] eb);
      answer_type a;
      int lim;
      int bud;
      int oldest;
      a = '0;
      lim = (cfg_limit > NSLOT) ? NSLOT : cfg_limit;
      bud = (cfg_budget > BUDGET_CAP) ? BUDGET_CAP : cfg_budget;
      if (kind == REQ_CLEAR) begin
         wipe_directory();
      end else if (kind == REQ_LOOKUP || kind == REQ_INSERT) begin
         if (lim == 0 || bud == 0 || eb > ENTRY_CAP || eb > bud) begin
            a.bypassed = 1'b1;
         end else if (kind == REQ_LOOKUP) begin
            for (int i = 0; i < lim; i++) begin
               if (dir_valid[i] && dir_tag[i] == tag && dir_klen[i] == klen) begin
                  age_now++;
                  dir_age[i] = age_now;
                  a.hit = 1'b1;
                  a.slot = 4'(i);
                  break;
               end
            end
         end else begin
            for (int r = 0; r <= NSLOT; r++) begin
               if (int'(held_bytes) + int'(eb) <= bud && held_count < lim) begin
                  for (int i = 0; i < lim; i++) begin
                     if (!dir_valid[i]) begin
                        dir_valid[i] = 1'b1;
                        dir_tag[i] = tag;
                        dir_klen[i] = klen;
                        dir_size[i] = eb;
                        age_now++;
                        dir_age[i] = age_now;
                        held_bytes += 25'(eb);
                        held_count++;
                        a.admitted = 1'b1;
                        a.slot = 4'(i);
                        break;
                     end
                  end
                  break;
               end
               oldest = -1;
               for (int i = 0; i < lim; i++)
                  if (dir_valid[i] && (oldest < 0 || dir_age[i] < dir_age[oldest])) oldest = i;
               if (oldest < 0) break;
               dir_valid[oldest] = 1'b0;
               held_bytes -= 25'(dir_size[oldest]);
               held_count--;
               a.ev_count++;
               a.ev_total += 25'(dir_size[oldest]);
            end
         end
      end
      a.occ_bytes = held_bytes;
      a.occ_count = held_count;
      return a;
   endfunction

   task automatic write_reg(logic idx, logic [24:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ENTRY_LIMIT) cfg_limit = val[4:0];
      else cfg_budget = val;
      @(posedge clock);
   endtask

   task automatic send_request(row_type r);
      answer_type a;
      int wait_cycles;
      wait_cycles = $urandom_range(0, 7);
      if (wait_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_key_tag <= r.tag;
      req_key_length <= r.klen;
      req_entry_bytes <= r.ebytes;
      do @(posedge clock); while (req_stall);
      a = predict_answer(r.kind, r.tag, r.klen, r.ebytes);
      if (r.has_answer) pending_answers.push_back(r.answer);
      else pending_answers.push_back(a);
   endtask

   // wait until every answer is back, then let the block settle before a csr write
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic row_type mk(logic [1:0] k, logic [63:0] t, logic [22:0] l,
                                  logic [22:0] e);
      row_type r;
      r.kind = k; r.tag = t; r.klen = l; r.ebytes = e;
      r.has_answer = 1'b0; r.answer = '0;
      return r;
   endfunction

   function automatic row_type mk_ans(logic [1:0] k, logic [63:0] t, logic [22:0] l,
                                      logic [22:0] e, answer_type a);
      row_type r;
      r = mk(k, t, l, e);
      r.has_answer = 1'b1;
      r.answer = a;
      return r;
   endfunction

   function automatic row_type random_row();
      int p;
      int sel;
      row_type r;
      p = $urandom_range(0, 99);
      sel = $urandom_range(0, 7);
      if (p < 40) r = mk(REQ_LOOKUP, tag_pool[sel], klen_pool[sel],
                         23'($urandom_range(0, 4096)));
      else if (p < 80) r = mk(REQ_INSERT, tag_pool[sel], klen_pool[sel],
                              ($urandom_range(0, 9) == 0) ? 23'($urandom_range(0, 23'h7F_FFFF))
                                                           : 23'($urandom_range(0, 23'h1F_FFFF)));
      else if (p < 84) r = mk(REQ_CLEAR, {$urandom, $urandom}, 23'($urandom), 23'($urandom));
      else if (p < 87) r = mk(2'd3, {$urandom, $urandom}, 23'($urandom), 23'($urandom));
      else begin
         // noise keys over the whole field range
         r = mk(2'($urandom_range(0, 1)), {$urandom, $urandom}, 23'($urandom),
                23'($urandom_range(0, 4096)));
         if ($urandom_range(0, 3) == 0) begin
            tag_pool[sel] = r.tag;
            klen_pool[sel] = r.klen;
         end
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      answer_type exp_a;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            exp_a = pending_answers.pop_front();
            if (rsp_bypassed !== exp_a.bypassed) begin
               $error("bypassed: exp %0d got %0d", exp_a.bypassed, rsp_bypassed); errors++;
            end
            if (rsp_hit !== exp_a.hit) begin
               $error("hit: exp %0d got %0d", exp_a.hit, rsp_hit); errors++;
            end
            if (rsp_slot !== exp_a.slot) begin
               $error("slot: exp %0d got %0d", exp_a.slot, rsp_slot); errors++;
            end
            if (rsp_admitted !== exp_a.admitted) begin
               $error("admitted: exp %0d got %0d", exp_a.admitted, rsp_admitted); errors++;
            end
            if (rsp_evicted_count !== exp_a.ev_count) begin
               $error("evicted_count: exp %0d got %0d", exp_a.ev_count, rsp_evicted_count);
               errors++;
            end
            if (rsp_evicted_total !== exp_a.ev_total) begin
               $error("evicted_total: exp %0d got %0d", exp_a.ev_total, rsp_evicted_total);
               errors++;
            end
            if (rsp_occupied_bytes !== exp_a.occ_bytes) begin
               $error("occupied_bytes: exp %0d got %0d", exp_a.occ_bytes, rsp_occupied_bytes);
               errors++;
            end
            if (rsp_entry_count !== exp_a.occ_count) begin
               $error("entry_count: exp %0d got %0d", exp_a.occ_count, rsp_entry_count);
               errors++;
            end
         end
      end
   end

   // result-side stalls: a random stall after each accepted item
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** size_aware_lru_cache_directory_top: FAILED **");
         $finish;
      end
   end

   initial begin
      row_type dir_rows[$];
      answer_type z;
      logic [4:0] limits [6];
      logic [24:0] budgets [6];
      limits = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd16};
      budgets = '{25'h100_0000, 25'd5000, 25'h1FF_FFFF, 25'h40_0000, 25'h80_0000,
                  25'h100_0000};
      cfg_limit = 5'd16;
      cfg_budget = BUDGET_CAP;
      wipe_directory();
      for (int i = 0; i < 8; i++) begin
         tag_pool[i] = {$urandom, $urandom};
         klen_pool[i] = 23'($urandom_range(0, 23'h40_0000));
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset configuration
      z = '0;
      dir_rows.push_back(mk_ans(REQ_LOOKUP, 64'h0, 23'h0, 23'h0, z));
      z = '0; z.admitted = 1; z.occ_bytes = 25'h40_0000; z.occ_count = 1;
      dir_rows.push_back(mk_ans(REQ_INSERT, '1, 23'h40_0000, 23'h40_0000, z));
      z = '0; z.hit = 1; z.occ_bytes = 25'h40_0000; z.occ_count = 1;
      dir_rows.push_back(mk_ans(REQ_LOOKUP, '1, 23'h40_0000, 23'h0, z));
      z = '0; z.bypassed = 1; z.occ_bytes = 25'h40_0000; z.occ_count = 1;
      dir_rows.push_back(mk_ans(REQ_INSERT, 64'h5, 23'd3, 23'h40_0001, z));
      dir_rows.push_back(mk_ans(REQ_LOOKUP, 64'h5, 23'd3, 23'h7F_FFFF, z));
      // miss on length only
      z = '0; z.occ_bytes = 25'h40_0000; z.occ_count = 1;
      dir_rows.push_back(mk_ans(REQ_LOOKUP, '1, 23'h3F_FFFF, 23'h0, z));
      // duplicate insert goes to the next slot, lookup hits the lower one
      dir_rows.push_back(mk(REQ_INSERT, '1, 23'h40_0000, 23'd0));
      dir_rows.push_back(mk(REQ_LOOKUP, '1, 23'h40_0000, 23'd0));
      // fill up to the budget so evictions start
      dir_rows.push_back(mk(REQ_INSERT, 64'hA, 23'd1, 23'h40_0000));
      dir_rows.push_back(mk(REQ_INSERT, 64'hB, 23'd1, 23'h40_0000));
      dir_rows.push_back(mk(REQ_INSERT, 64'hC, 23'd1, 23'h40_0000));
      dir_rows.push_back(mk(REQ_LOOKUP, 64'hA, 23'd1, 23'd0));
      dir_rows.push_back(mk(REQ_INSERT, 64'hD, 23'd1, 23'h40_0000));
      z = '0; z.occ_bytes = 25'h100_0000; z.occ_count = 4;
      dir_rows.push_back(mk_ans(2'd3, '1, '1, '1, z));
      z = '0;
      dir_rows.push_back(mk_ans(REQ_CLEAR, '1, '1, '1, z));
      for (int i = 0; i < 17; i++)
         dir_rows.push_back(mk(REQ_INSERT, 64'h100 + i, 23'd7, 23'(1000 + i)));
      foreach (dir_rows[i]) send_request(dir_rows[i]);
      drain();

      // random part, in phases across register settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_ENTRY_LIMIT, {20'd0, limits[ph]});
         write_reg(CSR_BYTE_BUDGET, budgets[ph]);
         // a lowered limit or a budget too small for all pending keys is exercised here
         for (int k = 0; k < RAND_ITEMS / 6; k++) begin
            send_request(random_row());
         end
         drain();
      end
      drain();
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("** size_aware_lru_cache_directory_top: PASSED **");
      end else begin
         $display("** size_aware_lru_cache_directory_top: FAILED **");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/salru_pkg.sv
rtl/salru_cell.sv
rtl/size_aware_lru_cache_directory_top.sv
verif/tb_top.sv
